// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, held off while rst_ni is low.
`define MSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define MSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/msd_pkg.sv =====
// Package with request and result types, codes and the segment table.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  localparam int NumDigits         = 4;
  localparam int ValueW            = 14;
  localparam int MaxValueDef       = 9999;
  localparam int MaxPointPlacesDef = 3;

  localparam logic       KindUpdate = 1'b0;
  localparam logic       KindTick   = 1'b1;
  localparam logic [3:0] BlankCode  = 4'hF;
  localparam logic [6:0] AllSegsOff = 7'h7F;

  typedef struct packed {
    logic        kind;
    logic [15:0] number;
    logic [7:0]  point_places;
  } in_t;

  typedef struct packed {
    logic [6:0] segments_off;
    logic [3:0] digit_enable;
    logic       point_off;
  } out_t;

  typedef logic [NumDigits-1:0][3:0] codes_t;

  function automatic logic [6:0] seg_off(input logic [3:0] code);
    logic [6:0] pat;
    case (code)
      4'd0:    pat = 7'h40;
      4'd1:    pat = 7'h79;
      4'd2:    pat = 7'h24;
      4'd3:    pat = 7'h30;
      4'd4:    pat = 7'h19;
      4'd5:    pat = 7'h12;
      4'd6:    pat = 7'h02;
      4'd7:    pat = 7'h78;
      4'd8:    pat = 7'h00;
      4'd9:    pat = 7'h10;
      default: pat = AllSegsOff;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msd_encode.sv =====
// Saturate, clamp, split into decimal digits and blank leading zeros.
`timescale 1ns / 1ps
`default_nettype none

module msd_encode import msd_pkg::*; #(
  parameter int MaxValue       = MaxValueDef,
  parameter int MaxPointPlaces = MaxPointPlacesDef
) (
  input  logic [15:0] number_i,
  input  logic [7:0]  point_places_i,
  output codes_t      codes_o,
  output logic [1:0]  places_o
);

  logic [ValueW-1:0] value;
  logic [27:0]       p1000;
  logic [26:0]       p100;
  logic [29:0]       p10;
  logic [3:0]        q1000;
  logic [6:0]        q100;
  logic [9:0]        q10;
  logic [6:0]        r1;
  logic [9:0]        r2;
  logic [ValueW-1:0] r3;
  codes_t            digits;
  logic [1:0]        point_pos;
  logic              has_point;
  logic [2:0]        blank;

  assign value    = (number_i > 16'(MaxValue)) ? ValueW'(MaxValue) : number_i[ValueW-1:0];
  assign places_o = (point_places_i > 8'(MaxPointPlaces)) ? 2'(MaxPointPlaces)
                                                           : point_places_i[1:0];

  // reciprocal multiply, exact for values below ten thousand
  assign p1000 = 28'(value) * 28'd8389;
  assign p100  = 27'(value) * 27'd5243;
  assign p10   = 30'(value) * 30'd52429;
  assign q1000 = p1000[26:23];
  assign q100  = p100[25:19];
  assign q10   = p10[28:19];

  assign r1 = q100 - (7'({q1000, 3'b000}) + 7'({q1000, 1'b0}));
  assign r2 = q10 - (10'({q100, 3'b000}) + 10'({q100, 1'b0}));
  assign r3 = value - (ValueW'({q10, 3'b000}) + ValueW'({q10, 1'b0}));

  assign digits[0] = q1000;
  assign digits[1] = r1[3:0];
  assign digits[2] = r2[3:0];
  assign digits[3] = r3[3:0];

  assign has_point = (places_o != 2'd0);
  assign point_pos = 2'(NumDigits - 1) - places_o;

  // stop blanking at the first nonzero digit or at the point digit
  assign blank[0] = (digits[0] == 4'd0) && !(has_point && point_pos == 2'd0);
  assign blank[1] = blank[0] && (digits[1] == 4'd0) && !(has_point && point_pos == 2'd1);
  assign blank[2] = blank[1] && (digits[2] == 4'd0) && !(has_point && point_pos == 2'd2);

  assign codes_o[0] = blank[0] ? BlankCode : digits[0];
  assign codes_o[1] = blank[1] ? BlankCode : digits[1];
  assign codes_o[2] = blank[2] ? BlankCode : digits[2];
  assign codes_o[3] = digits[3];

endmodule

`default_nettype wire

// ===== rtl/core/multiplexed_seven_segment_driver_top.sv =====
// Top level of the multiplexed four-digit seven-segment display driver.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    in_i  (in_t: kind, number, point_places)
//   out      output     out_valid_o / out_ready_i  out_o (out_t: segments, enable, point)
//
// One request per cycle is taken unless a tick waits behind a stalled result; each passes an
// input register, then one combinational pass into the display state and the result register.
// An update request gives no result; a tick request, after the input register, shows its result in the result register.
// Reset clears the digits to zero, the scan to the leftmost digit, no point, segments off.
// A stalled result holds; ticks behind it wait in the input register, updates still pass.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_driver_top import msd_pkg::*; #(
  parameter int MaxValue       = MaxValueDef,
  parameter int MaxPointPlaces = MaxPointPlacesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic       in_v_q;
  in_t        in_q;
  logic       adv;
  logic       do_update;
  logic       do_tick;

  codes_t     enc_codes;
  logic [1:0] enc_places;

  codes_t     codes_q;
  logic [1:0] places_q;
  logic [1:0] active_q;
  logic [6:0] held_q;
  logic [6:0] held_d;
  logic [3:0] code_sel;
  logic       code_ok;
  logic       show_point;

  logic       out_v_q;
  out_t       out_q;
  out_t       out_d;

  assign adv        = in_v_q && (in_q.kind == KindUpdate || !out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || adv;
  assign do_update  = adv && (in_q.kind == KindUpdate);
  assign do_tick    = adv && (in_q.kind == KindTick);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  msd_encode #(
    .MaxValue       (MaxValue),
    .MaxPointPlaces (MaxPointPlaces)
  ) u_msd_encode (
    .number_i       (in_q.number),
    .point_places_i (in_q.point_places),
    .codes_o        (enc_codes),
    .places_o       (enc_places)
  );

  assign code_sel   = codes_q[active_q];
  assign code_ok    = (code_sel <= 4'd9);
  assign held_d     = code_ok ? seg_off(code_sel) : held_q;
  assign show_point = (places_q != 2'd0) && (active_q == 2'(NumDigits - 1) - places_q);

  always_comb begin
    out_d.segments_off = held_d;
    out_d.digit_enable = code_ok ? (4'b0001 << active_q) : 4'b0000;
    out_d.point_off    = !show_point;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q  <= '0;
      places_q <= 2'd0;
      active_q <= 2'd0;
      held_q   <= AllSegsOff;
      out_v_q  <= 1'b0;
    end else begin
      if (do_update) begin
        codes_q  <= enc_codes;
        places_q <= enc_places;
      end
      if (do_tick) begin
        held_q   <= held_d;
        active_q <= active_q + 2'd1;
        out_v_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/msd_checker.sv =====
// Port-level checks on the display driver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msd_checker import msd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  `MSD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o), "result dropped or changed while stalled")
  `MSD_ASSERT(a_enable_onehot, out_valid_o |-> $onehot0(out_o.digit_enable), "digit enable not one-hot or zero")
  `MSD_ASSERT(a_point_not_blank, out_valid_o && !out_o.point_off |-> out_o.digit_enable != 4'b0000, "point shown on a blanked digit")
  `MSD_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_o |-> in_ready_o, "request refused with no result pending")

endmodule

bind multiplexed_seven_segment_driver_top msd_checker u_msd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
